// File: hdl/tofr_pkg.sv
// Shared types and constants for the time-of-flight ranging result processor.
// Used by tofr_ctrl, tofr_dp and the top level; depends on nothing else.
package tofr_pkg;

   // Item field widths
   localparam int CodeWidth  = 8;
   localparam int WordWidth  = 16;
   localparam int OutcWidth  = 4;
   localparam int DivWidth   = 32;
   localparam int CountWidth = $clog2(DivWidth);

   localparam int ReqDataWidth = 80;
   localparam int RspDataWidth = 72;

   // Range gain: (raw * 2011 + 1024) >> 11
   localparam int GainWidth = 11;
   localparam logic [GainWidth-1:0] GainFactor = 11'd2011;
   localparam int ProdWidth = WordWidth + GainWidth;
   localparam logic [ProdWidth-1:0] GainRound = 27'h400;

   localparam logic [WordWidth-1:0] TargetReset  = 16'd2560;
   localparam logic [WordWidth-1:0] SpadMidpoint = 16'h8000;
   localparam logic [WordWidth-1:0] Clip16       = 16'hFFFF;

   // Steps of the shared divider: full quotient, then the 16-bit need quotient
   localparam logic [CountWidth-1:0] Div1Last = CountWidth'(DivWidth - 1);
   localparam logic [CountWidth-1:0] Div2Last = CountWidth'(WordWidth - 1);

   // Device status byte codes
   localparam logic [CodeWidth-1:0] DEV_HW_A     = 8'd1;
   localparam logic [CodeWidth-1:0] DEV_HW_B     = 8'd2;
   localparam logic [CodeWidth-1:0] DEV_HW_C     = 8'd3;
   localparam logic [CodeWidth-1:0] DEV_SIGNAL   = 8'd4;
   localparam logic [CodeWidth-1:0] DEV_BOUNDS   = 8'd5;
   localparam logic [CodeWidth-1:0] DEV_SIGMA    = 8'd6;
   localparam logic [CodeWidth-1:0] DEV_WRAP     = 8'd7;
   localparam logic [CodeWidth-1:0] DEV_CLIPPED  = 8'd8;
   localparam logic [CodeWidth-1:0] DEV_RANGE_OK = 8'd9;
   localparam logic [CodeWidth-1:0] DEV_XTALK    = 8'd12;
   localparam logic [CodeWidth-1:0] DEV_MINRANGE = 8'd13;
   localparam logic [CodeWidth-1:0] DEV_HW_D     = 8'd17;
   localparam logic [CodeWidth-1:0] DEV_SYNC     = 8'd18;

   // Dense outcome codes
   localparam logic [OutcWidth-1:0] OUT_VALID    = 4'd0;
   localparam logic [OutcWidth-1:0] OUT_SIGMA    = 4'd1;
   localparam logic [OutcWidth-1:0] OUT_SIGNAL   = 4'd2;
   localparam logic [OutcWidth-1:0] OUT_MINRANGE = 4'd3;
   localparam logic [OutcWidth-1:0] OUT_BOUNDS   = 4'd4;
   localparam logic [OutcWidth-1:0] OUT_HW       = 4'd5;
   localparam logic [OutcWidth-1:0] OUT_NOWRAP   = 4'd6;
   localparam logic [OutcWidth-1:0] OUT_WRAP     = 4'd7;
   localparam logic [OutcWidth-1:0] OUT_XTALK    = 4'd8;
   localparam logic [OutcWidth-1:0] OUT_SYNC     = 4'd9;
   localparam logic [OutcWidth-1:0] OUT_CLIPPED  = 4'd10;
   localparam logic [OutcWidth-1:0] OUT_NONE     = 4'd11;

   typedef struct packed {
      logic load;      // capture input item, set up per-SPAD rate divide
      logic div_step;  // one restoring divide step
      logic setup2;    // set up target / per-SPAD rate divide
      logic finish;    // load result register, update held range
   } tofr_cmd_type;

   typedef struct packed {
      logic steps_done;  // current divide step is the last one
   } tofr_status_type;

endpackage

// File: hdl/tofr_ctrl.sv
// Sequencer for the ranging result processor: input handshake, divide phases,
// result register valid. Depends on tofr_pkg.
module tofr_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   input  tofr_pkg::tofr_status_type status,
   output tofr_pkg::tofr_cmd_type   cmd
);
   import tofr_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DIV1   = 3'd1;
   localparam logic [2:0] S_SETUP2 = 3'd2;
   localparam logic [2:0] S_DIV2   = 3'd3;
   localparam logic [2:0] S_DONE   = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE) && !reset;
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid && req_tready) begin
               cmd.load = 1'b1;
               state_in = S_DIV1;
            end
         end
         S_DIV1: begin
            cmd.div_step = 1'b1;
            if (status.steps_done) state_in = S_SETUP2;
         end
         S_SETUP2: begin
            cmd.setup2 = 1'b1;
            state_in   = S_DIV2;
         end
         S_DIV2: begin
            cmd.div_step = 1'b1;
            if (status.steps_done) state_in = S_DONE;
         end
         S_DONE: begin
            // wait until the result register can take the item
            if (out_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.finish) rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: hdl/tofr_dp.sv
// Datapath of the ranging result processor: input capture, range gain, status
// mapping, shared restoring divider, range hold and result register.
// Depends on tofr_pkg.
module tofr_dp (
   input  logic                                   clock,
   input  logic                                   reset,
   input  tofr_pkg::tofr_cmd_type                 cmd,
   output tofr_pkg::tofr_status_type              status,
   input  logic [tofr_pkg::ReqDataWidth-1:0]      req_tdata,
   output logic [tofr_pkg::RspDataWidth-1:0]      rsp_tdata,
   input  logic                                   csr_valid,
   input  logic [tofr_pkg::WordWidth-1:0]         csr_wdata
);
   import tofr_pkg::*;

   // Captured input item
   logic [CodeWidth-1:0] code_ff, streams_ff;
   logic [WordWidth-1:0] spads_ff, sig_ff, amb_ff, raw_ff;

   logic [WordWidth-1:0] target_ff;
   logic [WordWidth-1:0] held_ff;

   // Divider
   logic [DivWidth-1:0]   rem_ff, rem_in;
   logic [DivWidth-1:0]   quo_ff, quo_in;
   logic [DivWidth-1:0]   dvsr_ff, dvsr_in;
   logic [CountWidth-1:0] cnt_ff, cnt_in;
   logic                  phase2_ff, phase2_in;
   logic                  per_zero_ff, per_zero_in;
   logic                  clip_ff, clip_in;

   logic [DivWidth:0]     rem_sh, diff;
   logic [WordWidth:0]    total_sum;
   logic [WordWidth-1:0]  total_clip;
   logic [ProdWidth-1:0]  scaled_sum;
   logic [WordWidth-1:0]  scaled;
   logic [OutcWidth-1:0]  outcome;
   logic [WordWidth-1:0]  range_new;
   logic [WordWidth-1:0]  select;

   logic [WordWidth-1:0]  out_range_ff, out_spad_ff, out_sig_ff, out_amb_ff;
   logic [OutcWidth-1:0]  out_outc_ff;

   function automatic logic [OutcWidth-1:0] map_status(
      input logic [CodeWidth-1:0] code,
      input logic [CodeWidth-1:0] streams
   );
      logic [OutcWidth-1:0] res;
      case (code)
         DEV_HW_A, DEV_HW_B, DEV_HW_C, DEV_HW_D: res = OUT_HW;
         DEV_MINRANGE: res = OUT_MINRANGE;
         DEV_SYNC:     res = OUT_SYNC;
         DEV_BOUNDS:   res = OUT_BOUNDS;
         DEV_SIGNAL:   res = OUT_SIGNAL;
         DEV_SIGMA:    res = OUT_SIGMA;
         DEV_WRAP:     res = OUT_WRAP;
         DEV_XTALK:    res = OUT_XTALK;
         DEV_CLIPPED:  res = OUT_CLIPPED;
         DEV_RANGE_OK: res = (streams == '0) ? OUT_NOWRAP : OUT_VALID;
         default:      res = OUT_NONE;
      endcase
      return res;
   endfunction

   // Total rate from the live input, clipped to 16 bits
   assign total_sum  = {1'b0, req_tdata[63:48]} + {1'b0, req_tdata[47:32]};
   assign total_clip = total_sum[WordWidth] ? Clip16 : total_sum[WordWidth-1:0];

   // Restoring divide step
   assign rem_sh = {rem_ff, quo_ff[DivWidth-1]};
   assign diff   = rem_sh - {1'b0, dvsr_ff};

   assign status.steps_done = (cnt_ff == (phase2_ff ? Div2Last : Div1Last));

   always_comb begin
      rem_in      = rem_ff;
      quo_in      = quo_ff;
      dvsr_in     = dvsr_ff;
      cnt_in      = cnt_ff;
      phase2_in   = phase2_ff;
      per_zero_in = per_zero_ff;
      clip_in     = clip_ff;
      if (cmd.load) begin
         rem_in    = '0;
         quo_in    = {total_clip, {WordWidth{1'b0}}};
         dvsr_in   = {{(DivWidth-WordWidth){1'b0}}, req_tdata[31:16]};
         cnt_in    = '0;
         phase2_in = 1'b0;
      end else if (cmd.setup2) begin
         // target < per-SPAD rate keeps the need quotient within 16 bits,
         // so the upper half of the long division is just the target itself
         dvsr_in     = quo_ff;
         rem_in      = {{(DivWidth-WordWidth){1'b0}}, target_ff};
         quo_in      = '0;
         per_zero_in = (quo_ff == '0);
         clip_in     = ({{(DivWidth-WordWidth){1'b0}}, target_ff} >= quo_ff);
         cnt_in      = '0;
         phase2_in   = 1'b1;
      end else if (cmd.div_step) begin
         cnt_in = cnt_ff + 1'b1;
         if (!diff[DivWidth]) begin
            rem_in = diff[DivWidth-1:0];
            quo_in = {quo_ff[DivWidth-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[DivWidth-1:0];
            quo_in = {quo_ff[DivWidth-2:0], 1'b0};
         end
      end
   end

   // Range gain and outcome from the captured item
   assign scaled_sum = raw_ff * GainFactor + GainRound;
   assign scaled     = scaled_sum[ProdWidth-1:GainWidth];
   assign outcome    = map_status(code_ff, streams_ff);
   assign range_new  = (outcome == OUT_VALID) ? scaled : held_ff;

   always_comb begin
      if (spads_ff == '0 || per_zero_ff) select = SpadMidpoint;
      else if (clip_ff) select = Clip16;
      else select = quo_ff[WordWidth-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= TargetReset;
         held_ff   <= '0;
         cnt_ff    <= '0;
         phase2_ff <= 1'b0;
      end else begin
         if (csr_valid) target_ff <= csr_wdata;
         if (cmd.finish) held_ff <= range_new;
         cnt_ff    <= cnt_in;
         phase2_ff <= phase2_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      dvsr_ff     <= dvsr_in;
      per_zero_ff <= per_zero_in;
      clip_ff     <= clip_in;
      if (cmd.load) begin
         code_ff    <= req_tdata[7:0];
         streams_ff <= req_tdata[15:8];
         spads_ff   <= req_tdata[31:16];
         sig_ff     <= req_tdata[47:32];
         amb_ff     <= req_tdata[63:48];
         raw_ff     <= req_tdata[79:64];
      end
      if (cmd.finish) begin
         out_range_ff <= range_new;
         out_outc_ff  <= outcome;
         out_spad_ff  <= select;
         out_sig_ff   <= sig_ff;
         out_amb_ff   <= amb_ff;
      end
   end

   assign rsp_tdata = {4'b0000, out_amb_ff, out_sig_ff, out_spad_ff, out_outc_ff,
                       out_range_ff};

endmodule

// File: hdl/tof_ranging_result_processor.sv
// Time-of-flight ranging result processor.
// req channel: one raw ranging result per item. rsp channel: one processed
// result per item (gain corrected held range, outcome code, next SPAD select,
// rates passed on). csr channel: writes target_rate, ready whenever reset is
// low; write it only while no item is in flight.
// Steps: after the input item is accepted, a shared one-bit-per-cycle restoring
// divider runs 32 steps for the per-SPAD rate, then a setup step, 16 steps for
// the required SPAD count and a finish step that registers the result. A new
// item is accepted once the sequencer is back in idle, so the block works on
// one item at a time.
// The result sits in an output register, so the next item is accepted while
// it waits. If the receiver stalls, the block holds a finished second result
// in its last state until the output register frees up.
// Reset (synchronous, active high) sets target_rate to 2560, clears the held
// range to zero and drops rsp_tvalid; the block is ready once reset is low.
// Uses tofr_pkg, tofr_ctrl and tofr_dp.
module tof_ranging_result_processor (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // raw_status_code[7:0], streams[15:8], spad_count[31:16],
   // signal_rate[47:32], ambient_rate[63:48], raw_range[79:64]
   input  logic [tofr_pkg::ReqDataWidth-1:0]   req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // range_out[15:0], outcome[19:16], spad_select[35:20],
   // signal_rate_out[51:36], ambient_rate_out[67:52], zero[71:68]
   output logic [tofr_pkg::RspDataWidth-1:0]   rsp_tdata,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [tofr_pkg::WordWidth-1:0]      csr_wdata
);
   import tofr_pkg::*;

   tofr_cmd_type    cmd;
   tofr_status_type status;

   assign csr_ready = !reset;

   tofr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   tofr_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_tdata (req_tdata),
      .rsp_tdata (rsp_tdata),
      .csr_valid (csr_valid),
      .csr_wdata (csr_wdata)
   );

endmodule

// File: bench/tb_tof_ranging_result_processor.sv
// Self-checking bench for tof_ranging_result_processor: a directed table, then
// random ranging results over several target_rate settings and idle patterns.
// Depends on tofr_pkg and the RTL top level only.
module tb_tof_ranging_result_processor;
   import tofr_pkg::*;

   localparam int QuietLimit   = 4000;  // cycles with no handshake at all
   localparam int PhaseItems   = 320;
   localparam int NumPhases    = 6;
   localparam int HoldAt       = 1500;  // results seen before the long stall
   localparam int HoldCycles   = 600;
   localparam int DrainCycles  = 60;

   typedef struct packed {
      logic [CodeWidth-1:0] status;
      logic [7:0]           streams;
      logic [WordWidth-1:0] spads;
      logic [WordWidth-1:0] sig;
      logic [WordWidth-1:0] amb;
      logic [WordWidth-1:0] raw;
   } raw_result_type;

   typedef struct packed {
      logic [WordWidth-1:0] range_out;
      logic [OutcWidth-1:0] outcome;
      logic [WordWidth-1:0] spad_select;
      logic [WordWidth-1:0] sig;
      logic [WordWidth-1:0] amb;
   } ranging_out_type;

   typedef struct packed {
      logic            typed;  // out holds a hand-computed result
      raw_result_type  item;
      ranging_out_type out;
   } dir_row_type;

   localparam int NumRows = 21;
   localparam dir_row_type DirRows [NumRows] = '{
      // unknown code right after reset, all extremes, zero SPAD count
      '{1'b1, '{8'd0, 8'd0, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF},
              '{16'd0, OUT_NONE, 16'h8000, 16'hFFFF, 16'hFFFF}},
      // range ok on the first stream is nowrap, held range untouched
      '{1'b1, '{DEV_RANGE_OK, 8'd0, 16'h0000, 16'h0000, 16'h0000, 16'd1234},
              '{16'd0, OUT_NOWRAP, 16'h8000, 16'h0000, 16'h0000}},
      '{1'b1, '{DEV_RANGE_OK, 8'hFF, 16'h0000, 16'h1234, 16'h4321, 16'hFFFF},
              '{16'd64351, OUT_VALID, 16'h8000, 16'h1234, 16'h4321}},
      // required SPADs clip to 0xFFFF
      '{1'b1, '{DEV_HW_A, 8'd1, 16'hFFFF, 16'h0001, 16'h0000, 16'h0000},
              '{16'd64351, OUT_HW, 16'hFFFF, 16'h0001, 16'h0000}},
      // rate sum clips, required SPADs round down to zero
      '{1'b1, '{DEV_HW_B, 8'd1, 16'h0001, 16'hFFFF, 16'h0001, 16'd500},
              '{16'd64351, OUT_HW, 16'h0000, 16'hFFFF, 16'h0001}},
      // zero per-SPAD rate
      '{1'b1, '{DEV_RANGE_OK, 8'd1, 16'h0100, 16'h0000, 16'h0000, 16'h0000},
              '{16'd0, OUT_VALID, 16'h8000, 16'h0000, 16'h0000}},
      '{1'b0, '{DEV_RANGE_OK, 8'd2, 16'h0A00, 16'h0280, 16'h0040, 16'h0001}, '0},
      '{1'b0, '{DEV_HW_C, 8'd3, 16'h1800, 16'h0100, 16'h0100, 16'd800}, '0},
      '{1'b0, '{DEV_SIGNAL, 8'd4, 16'h2000, 16'h0010, 16'h0200, 16'd900}, '0},
      '{1'b0, '{DEV_BOUNDS, 8'd5, 16'h0800, 16'h8000, 16'h7FFF, 16'd1000}, '0},
      '{1'b0, '{DEV_SIGMA, 8'd6, 16'h4000, 16'h0400, 16'h0001, 16'd1100}, '0},
      '{1'b0, '{DEV_WRAP, 8'd7, 16'h0001, 16'h0000, 16'h0001, 16'd1200}, '0},
      '{1'b0, '{DEV_CLIPPED, 8'd8, 16'h8000, 16'h1000, 16'h1000, 16'd1300}, '0},
      '{1'b0, '{DEV_XTALK, 8'd9, 16'h0C00, 16'h0300, 16'h0300, 16'd1400}, '0},
      '{1'b0, '{DEV_MINRANGE, 8'd10, 16'h0900, 16'h0020, 16'h0020, 16'd1500}, '0},
      '{1'b0, '{DEV_HW_D, 8'd11, 16'h0700, 16'h0500, 16'h0000, 16'd1600}, '0},
      '{1'b0, '{DEV_SYNC, 8'd12, 16'h0600, 16'h0000, 16'h0500, 16'd1700}, '0},
      '{1'b0, '{8'd10, 8'd13, 16'h0500, 16'h0123, 16'h0456, 16'd1800}, '0},
      '{1'b0, '{8'd11, 8'd14, 16'h0400, 16'h0789, 16'h0ABC, 16'd1900}, '0},
      '{1'b0, '{8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'd2000}, '0},
      '{1'b0, '{DEV_RANGE_OK, 8'h80, 16'h0300, 16'h0200, 16'h0100, 16'h1000}, '0}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [ReqDataWidth-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RspDataWidth-1:0] rsp_tdata;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [WordWidth-1:0] csr_wdata = '0;

   // model state
   logic [WordWidth-1:0] target_rate = TargetReset;
   logic [WordWidth-1:0] held_range = '0;

   ranging_out_type processed_q [$];
   int in_flight = 0;
   int results_seen = 0;
   int mismatches = 0;
   int quiet_cycles = 0;
   int snd_idle_pct = 0;
   int rcv_idle_pct = 0;
   int hold_left = 0;
   logic hold_done = 1'b0;

   tof_ranging_result_processor dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Expected result of one ranging item; updates the held range.
   function automatic ranging_out_type process_ranging(input raw_result_type r);
      longint unsigned total;
      longint unsigned per_spad;
      longint unsigned need;
      logic [31:0] scaled;
      ranging_out_type o;
      case (r.status)
         DEV_HW_A, DEV_HW_B, DEV_HW_C, DEV_HW_D: o.outcome = OUT_HW;
         DEV_MINRANGE: o.outcome = OUT_MINRANGE;
         DEV_SYNC:     o.outcome = OUT_SYNC;
         DEV_BOUNDS:   o.outcome = OUT_BOUNDS;
         DEV_SIGNAL:   o.outcome = OUT_SIGNAL;
         DEV_SIGMA:    o.outcome = OUT_SIGMA;
         DEV_WRAP:     o.outcome = OUT_WRAP;
         DEV_XTALK:    o.outcome = OUT_XTALK;
         DEV_CLIPPED:  o.outcome = OUT_CLIPPED;
         DEV_RANGE_OK: o.outcome = (r.streams == 8'd0) ? OUT_NOWRAP : OUT_VALID;
         default:      o.outcome = OUT_NONE;
      endcase
      scaled = (32'(r.raw) * 32'd2011 + 32'd1024) / 32'd2048;
      if (o.outcome == OUT_VALID) begin
         held_range = scaled[15:0];
      end
      if (r.spads == '0) begin
         o.spad_select = SpadMidpoint;
      end else begin
         total = longint'(r.sig) + longint'(r.amb);
         if (total > 64'hFFFF) begin
            total = 64'hFFFF;
         end
         per_spad = (total << 16) / longint'(r.spads);
         if (per_spad == 0) begin
            o.spad_select = SpadMidpoint;
         end else begin
            need = (longint'(target_rate) << 16) / per_spad;
            o.spad_select = (need > 64'hFFFF) ? Clip16 : need[15:0];
         end
      end
      o.range_out = held_range;
      o.sig = r.sig;
      o.amb = r.amb;
      return o;
   endfunction

   // Mostly well-formed results with random content, some junk status codes.
   function automatic raw_result_type random_ranging_item();
      raw_result_type r;
      int pick;
      r.streams = ($urandom_range(4) == 0) ? 8'd0 : 8'($urandom);
      pick = $urandom_range(99);
      if (pick < 40) begin
         r.status = DEV_RANGE_OK;
      end else if (pick < 80) begin
         case ($urandom_range(11))
            0:  r.status = DEV_HW_A;
            1:  r.status = DEV_HW_B;
            2:  r.status = DEV_HW_C;
            3:  r.status = DEV_HW_D;
            4:  r.status = DEV_SIGNAL;
            5:  r.status = DEV_BOUNDS;
            6:  r.status = DEV_SIGMA;
            7:  r.status = DEV_WRAP;
            8:  r.status = DEV_CLIPPED;
            9:  r.status = DEV_XTALK;
            10: r.status = DEV_MINRANGE;
            default: r.status = DEV_SYNC;
         endcase
      end else begin
         r.status = 8'($urandom);
      end
      pick = $urandom_range(9);
      if (pick == 0) r.spads = '0;
      else if (pick < 3) r.spads = 16'($urandom_range(255, 1));
      else r.spads = 16'($urandom);
      pick = $urandom_range(9);
      if (pick == 0) begin
         r.sig = '0;
         r.amb = '0;
      end else if (pick < 3) begin
         r.sig = 16'($urandom_range(255));
         r.amb = 16'($urandom_range(255));
      end else begin
         r.sig = 16'($urandom);
         r.amb = 16'($urandom);
      end
      r.raw = 16'($urandom);
      return r;
   endfunction

   task automatic offer_item(input raw_result_type r, input logic typed,
                             input ranging_out_type typed_out);
      ranging_out_type p;
      @(negedge clock);
      while ($urandom_range(99) < snd_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tdata <= {r.raw, r.amb, r.sig, r.spads, r.streams, r.status};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      p = process_ranging(r);
      processed_q.push_back(typed ? typed_out : p);
      in_flight++;
   endtask

   task automatic set_target_rate(input logic [WordWidth-1:0] value);
      @(negedge clock);
      csr_wdata <= value;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      target_rate = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic stop_and_drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (in_flight != 0) @(posedge clock);
   endtask

   task automatic check_field(input string what, input logic [WordWidth-1:0] exp_v,
                              input logic [WordWidth-1:0] got_v);
      if (got_v !== exp_v) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %h, actual %h", $time, what, exp_v, got_v);
      end
   endtask

   // receiver: random backpressure plus one long stall while the sender keeps going
   always @(negedge clock) begin
      if (!hold_done && results_seen >= HoldAt) begin
         hold_left = HoldCycles;
         hold_done = 1'b1;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rcv_idle_pct);
      end
   end

   always @(posedge clock) begin
      ranging_out_type exp_r;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (processed_q.size() == 0) begin
            mismatches++;
            $display("%0t: result with nothing expected, actual %h", $time, rsp_tdata);
         end else begin
            exp_r = processed_q.pop_front();
            in_flight--;
            check_field("range_out", exp_r.range_out, rsp_tdata[15:0]);
            check_field("outcome", 16'(exp_r.outcome), 16'(rsp_tdata[19:16]));
            check_field("spad_select", exp_r.spad_select, rsp_tdata[35:20]);
            check_field("signal_rate_out", exp_r.sig, rsp_tdata[51:36]);
            check_field("ambient_rate_out", exp_r.amb, rsp_tdata[67:52]);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready) || reset) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles == QuietLimit) begin
         $display("tb: failure");
         $finish;
      end
   end

   localparam logic [WordWidth-1:0] PhaseTarget [NumPhases] =
      '{16'hFFFF, 16'h0000, 16'h0001, 16'h0A00, 16'h0000, 16'h0080};

   initial begin
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < NumRows; i++) begin
         offer_item(DirRows[i].item, DirRows[i].typed, DirRows[i].out);
      end
      stop_and_drain();

      for (int ph = 0; ph < NumPhases; ph++) begin
         if (ph == 4) begin
            set_target_rate(16'($urandom));
         end else begin
            set_target_rate(PhaseTarget[ph]);
         end
         if (ph < 2) begin
            snd_idle_pct = 35;
            rcv_idle_pct = 56;
         end else if (ph < 4) begin
            snd_idle_pct = 56;
            rcv_idle_pct = 35;
         end else begin
            snd_idle_pct = 0;
            rcv_idle_pct = 0;
         end
         for (int n = 0; n < PhaseItems; n++) begin
            offer_item(random_ranging_item(), 1'b0, '0);
         end
         stop_and_drain();
      end

      repeat (DrainCycles) @(posedge clock);
      if (mismatches == 0 && processed_q.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// File: filelist.f
hdl/tofr_pkg.sv
hdl/tofr_ctrl.sv
hdl/tofr_dp.sv
hdl/tof_ranging_result_processor.sv
bench/tb_tof_ranging_result_processor.sv
